/* rtl/assert_macros.svh */
// assertion macros for the directory name table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational check sampled at every rising clock edge outside reset
`define DNT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DNT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dnt_pkg.sv */
// types, constants and name helper for the directory name table
`default_nettype none

package dnt_pkg;

  localparam int ENTRIES      = 16;
  localparam int NAME_BYTES   = 8;
  localparam int SECTOR_COUNT = 1024;

  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NAME_W   = 64;
  localparam int SECTOR_W = 10;
  localparam int SLOT_W   = 4;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // search item walking down the row of cells
  typedef struct packed {
    logic                act;
    logic [CMD_W-1:0]    cmd;
    logic [NAME_W-1:0]   name;
    logic                kind;
    logic [SECTOR_W-1:0] sector;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [SECTOR_W-1:0] hit_sector;
    logic                free;
    logic [IDX_W-1:0]    free_idx;
  } token_t;

  // update broadcast to all cells
  typedef struct packed {
    logic                set;
    logic                clr;
    logic [IDX_W-1:0]    idx;
    logic [NAME_W-1:0]   name;
    logic                kind;
    logic [SECTOR_W-1:0] sector;
  } wr_t;

  // keep the low NAME_BYTES bytes up to the first zero byte
  function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              live;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'h00) live = 1'b0;
      if (live) res[8*b +: 8] = raw[8*b +: 8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/dnt_cell.sv */
// one table entry that checks the passing search item against its contents and marks itself free when empty
`default_nettype none

module dnt_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [dnt_pkg::IDX_W-1:0] my_idx,
  input  wire dnt_pkg::token_t           tok_in,
  input  wire dnt_pkg::wr_t              wr,
  output dnt_pkg::token_t                tok_out
);

  logic                         valid;
  logic                         kind;
  logic [dnt_pkg::NAME_W-1:0]   name;
  logic [dnt_pkg::SECTOR_W-1:0] sector;
  logic                         match;
  logic                         wr_here;
  dnt_pkg::token_t              tok_next;

  assign match   = valid && (kind == tok_in.kind) && (name == tok_in.name);
  assign wr_here = (wr.idx == my_idx);

  always_comb begin
    tok_next = tok_in;
    if (match && !tok_in.hit) begin
      tok_next.hit        = 1'b1;
      tok_next.hit_idx    = my_idx;
      tok_next.hit_sector = sector;
    end
    if (!valid && !tok_in.free) begin
      tok_next.free     = 1'b1;
      tok_next.free_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      kind  <= 1'b0;
    end else if (wr.set && wr_here) begin
      valid <= 1'b1;
      kind  <= wr.kind;
    end else if (wr.clr && wr_here) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set && wr_here) begin
      name   <= wr.name;
      sector <= wr.sector;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.act <= 1'b0;
    end else begin
      tok_out.act <= tok_in.act;
    end
    tok_out.cmd        <= tok_next.cmd;
    tok_out.name       <= tok_next.name;
    tok_out.kind       <= tok_next.kind;
    tok_out.sector     <= tok_next.sector;
    tok_out.hit        <= tok_next.hit;
    tok_out.hit_idx    <= tok_next.hit_idx;
    tok_out.hit_sector <= tok_next.hit_sector;
    tok_out.free       <= tok_next.free;
    tok_out.free_idx   <= tok_next.free_idx;
  end

endmodule

`default_nettype wire

/* rtl/directory_name_table.sv */
// directory name table: an accepted item walks through the launch register, the row of entry
// cells and the finish register, which holds it until the output register is free
// one item at a time; a new item is taken the cycle after the previous result is loaded
// the table update happens in the cycle the result is loaded
// synchronous reset clears all valid and kind bits and empties the pipeline at once
`default_nettype none

`include "assert_macros.svh"

module directory_name_table (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dnt_pkg::CMD_W-1:0]      command,
  input  wire logic [dnt_pkg::NAME_W-1:0]     entry_name,
  input  wire logic                           is_directory,
  input  wire logic [dnt_pkg::SECTOR_W-1:0]   header_sector,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [dnt_pkg::STATUS_W-1:0]   status,
  output logic      [dnt_pkg::SLOT_W-1:0]     slot_index,
  output logic      [dnt_pkg::SECTOR_W-1:0]   found_sector
);

  dnt_pkg::token_t tok [dnt_pkg::ENTRIES+1];
  dnt_pkg::token_t fin;
  dnt_pkg::wr_t    wr;

  logic                             busy;
  logic                             in_fire;
  logic                             fire;
  logic [dnt_pkg::ENTRIES+1:0]      acts;
  logic [dnt_pkg::STATUS_W-1:0]     status_next;
  logic [dnt_pkg::IDX_W-1:0]        idx_next;
  logic [dnt_pkg::SECTOR_W-1:0]     sector_next;

  assign in_ready = !busy && !rst;
  assign in_fire  = in_valid && in_ready;
  assign fire     = fin.act && (!out_valid || out_ready);

  // launch register at the head of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].act <= 1'b0;
    end else begin
      tok[0].act <= in_fire;
    end
    if (in_fire) begin
      tok[0].cmd        <= command;
      tok[0].name       <= dnt_pkg::normalize_name(entry_name);
      tok[0].kind       <= is_directory;
      tok[0].sector     <= header_sector;
      tok[0].hit        <= 1'b0;
      tok[0].hit_idx    <= '0;
      tok[0].hit_sector <= '0;
      tok[0].free       <= 1'b0;
      tok[0].free_idx   <= '0;
    end
  end

  for (genvar i = 0; i < dnt_pkg::ENTRIES; i++) begin : g_cell
    dnt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (dnt_pkg::IDX_W'(i)),
      .tok_in  (tok[i]),
      .wr      (wr),
      .tok_out (tok[i+1])
    );
    assign acts[i+1] = tok[i+1].act;
  end

  assign acts[0]                    = tok[0].act;
  assign acts[dnt_pkg::ENTRIES+1]   = fin.act;

  // finished item waits here until the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      fin.act <= 1'b0;
    end else if (tok[dnt_pkg::ENTRIES].act) begin
      fin.act <= 1'b1;
    end else if (fire) begin
      fin.act <= 1'b0;
    end
    if (tok[dnt_pkg::ENTRIES].act) begin
      fin.cmd        <= tok[dnt_pkg::ENTRIES].cmd;
      fin.name       <= tok[dnt_pkg::ENTRIES].name;
      fin.kind       <= tok[dnt_pkg::ENTRIES].kind;
      fin.sector     <= tok[dnt_pkg::ENTRIES].sector;
      fin.hit        <= tok[dnt_pkg::ENTRIES].hit;
      fin.hit_idx    <= tok[dnt_pkg::ENTRIES].hit_idx;
      fin.hit_sector <= tok[dnt_pkg::ENTRIES].hit_sector;
      fin.free       <= tok[dnt_pkg::ENTRIES].free;
      fin.free_idx   <= tok[dnt_pkg::ENTRIES].free_idx;
    end
  end

  always_comb begin
    status_next = dnt_pkg::ST_NOT_FOUND;
    idx_next    = '0;
    sector_next = '0;
    case (fin.cmd)
      dnt_pkg::CMD_FIND: begin
        if (fin.hit) begin
          status_next = dnt_pkg::ST_OK;
          idx_next    = fin.hit_idx;
          sector_next = fin.hit_sector;
        end
      end
      dnt_pkg::CMD_ADD: begin
        if (fin.hit) begin
          status_next = dnt_pkg::ST_DUPLICATE;
        end else if (fin.free) begin
          status_next = dnt_pkg::ST_OK;
          idx_next    = fin.free_idx;
        end else begin
          status_next = dnt_pkg::ST_FULL;
        end
      end
      dnt_pkg::CMD_REMOVE: begin
        if (fin.hit) begin
          status_next = dnt_pkg::ST_OK;
          idx_next    = fin.hit_idx;
        end
      end
      default: begin
        status_next = dnt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    wr.set    = fire && (fin.cmd == dnt_pkg::CMD_ADD) && !fin.hit && fin.free;
    wr.clr    = fire && (fin.cmd == dnt_pkg::CMD_REMOVE) && fin.hit;
    wr.idx    = (fin.cmd == dnt_pkg::CMD_ADD) ? fin.free_idx : fin.hit_idx;
    wr.name   = fin.name;
    wr.kind   = fin.kind;
    wr.sector = fin.sector;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status       <= status_next;
      slot_index   <= dnt_pkg::SLOT_W'(idx_next);
      found_sector <= sector_next;
    end
  end

  `DNT_ASSERT(a_one_item, $onehot0(acts), "more than one item in flight")
  `DNT_ASSERT(a_idle_empty, busy || !(|acts), "item in flight while idle")
  `DNT_ASSERT_NEXT(a_fire_done, fire, !busy && !fin.act, "busy after result loaded")
  `DNT_ASSERT(a_fail_zero,
    !out_valid || status == dnt_pkg::ST_OK || (slot_index == '0 && found_sector == '0),
    "nonzero fields on failed item")

endmodule

`default_nettype wire

/* dv/directory_name_table_checker.sv */
// checker for the directory name table: tracks the table, predicts each result and compares
module directory_name_table_checker
  import dnt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [NAME_W-1:0]     entry_name,
  input  logic                  is_directory,
  input  logic [SECTOR_W-1:0]   header_sector,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [STATUS_W-1:0]   status,
  input  logic [SLOT_W-1:0]     slot_index,
  input  logic [SECTOR_W-1:0]   found_sector,
  output int unsigned           failures,
  output int unsigned           pending,
  output logic [3:0][31:0]      status_tally
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
  } lookup_result_t;

  lookup_result_t    awaited_q[$];
  bit                entry_live   [ENTRIES];
  bit                entry_dir    [ENTRIES];
  logic [NAME_W-1:0] stored_name  [ENTRIES];
  logic [SECTOR_W-1:0] stored_sector [ENTRIES];
  int unsigned       result_no;

  initial begin
    failures     = 0;
    pending      = 0;
    status_tally = '0;
    result_no    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    failures++;
  endtask

  // bytes past the first zero byte do not count
  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    int n;
    kept = '0;
    n = 0;
    while (n < NAME_BYTES && raw[8*n +: 8] != 8'h00) begin
      kept[8*n +: 8] = raw[8*n +: 8];
      n++;
    end
    return kept;
  endfunction

  function automatic int find_entry(input logic [NAME_W-1:0] key, input logic dir);
    for (int i = 0; i < ENTRIES; i++)
      if (entry_live[i] && entry_dir[i] == dir && stored_name[i] == key) return i;
    return -1;
  endfunction

  function automatic lookup_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [NAME_W-1:0] raw,
                                                   input logic dir,
                                                   input logic [SECTOR_W-1:0] sec);
    lookup_result_t res;
    logic [NAME_W-1:0] key;
    int hit;
    int spot;
    res = '0;
    res.status = ST_NOT_FOUND;
    key = trim_name(raw);
    hit = find_entry(key, dir);
    spot = -1;
    case (cmd)
      CMD_FIND: begin
        if (hit >= 0) begin
          res.status = ST_OK;
          res.slot   = SLOT_W'(hit);
          res.sector = stored_sector[hit];
        end
      end
      CMD_ADD: begin
        if (hit >= 0) begin
          res.status = ST_DUPLICATE;
        end else begin
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!entry_live[i]) spot = i;
          if (spot < 0) begin
            res.status = ST_FULL;
          end else begin
            entry_live[spot]    = 1'b1;
            entry_dir[spot]     = dir;
            stored_name[spot]   = key;
            stored_sector[spot] = sec;
            res.status = ST_OK;
            res.slot   = SLOT_W'(spot);
          end
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          entry_live[hit] = 1'b0;
          res.status = ST_OK;
          res.slot   = SLOT_W'(hit);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      awaited_q.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        entry_live[i] = 1'b0;
        entry_dir[i]  = 1'b0;
      end
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding", result_no));
        end else begin
          want = awaited_q.pop_front();
          if (status != want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      result_no, status, want.status));
          if (slot_index != want.slot)
            report_mismatch($sformatf("result %0d slot_index %0d, expected %0d",
                                      result_no, slot_index, want.slot));
          if (found_sector != want.sector)
            report_mismatch($sformatf("result %0d found_sector %0d, expected %0d",
                                      result_no, found_sector, want.sector));
        end
        status_tally[status] = status_tally[status] + 1;
        result_no++;
      end
      if (in_valid && in_ready)
        awaited_q.push_back(apply_command(command, entry_name, is_directory, header_sector));
    end
    pending <= awaited_q.size();
  end

endmodule

/* dv/directory_name_table_test.sv */
// testbench top for the directory name table: clock, reset, stimulus and verdict
module directory_name_table_test;
  import dnt_pkg::*;

  localparam int LATENCY      = ENTRIES + 3;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 700;
  localparam int POOL         = 24;
  localparam int EPISODE      = 30;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic FILE_KIND = 1'b0;
  localparam logic DIR_KIND  = 1'b1;
  localparam logic [SECTOR_W-1:0] TOP_SECTOR = '1;

  localparam logic [NAME_W-1:0] NAME_AB        = 64'h0000_0000_0000_6261;
  localparam logic [NAME_W-1:0] NAME_AB_JUNK   = 64'h0000_0000_7800_6261;
  localparam logic [NAME_W-1:0] NAME_CD        = 64'h0000_0000_0000_6463;
  localparam logic [NAME_W-1:0] NAME_EMPTY_JUNK = 64'hffff_ffff_ffff_ff00;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                out_ready = 1'b0;
  logic [CMD_W-1:0]    command = CMD_FIND;
  logic [NAME_W-1:0]   entry_name = '0;
  logic                is_directory = 1'b0;
  logic [SECTOR_W-1:0] header_sector = '0;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic [SECTOR_W-1:0] found_sector;

  int unsigned      failures;
  int unsigned      pending;
  logic [3:0][31:0] status_tally;
  int unsigned      in_idle_pct = 0;
  int unsigned      out_idle_pct = 0;
  int unsigned      sent = 0;
  int unsigned      quiet = 0;
  logic [NAME_W-1:0] name_pool [POOL];

  directory_name_table DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .entry_name    (entry_name),
    .is_directory  (is_directory),
    .header_sector (header_sector),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_index    (slot_index),
    .found_sector  (found_sector)
  );

  directory_name_table_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .entry_name    (entry_name),
    .is_directory  (is_directory),
    .header_sector (header_sector),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_index    (slot_index),
    .found_sector  (found_sector),
    .failures      (failures),
    .pending       (pending),
    .status_tally  (status_tally)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [NAME_W-1:0] name,
                           input logic dir, input logic [SECTOR_W-1:0] sec);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    entry_name    <= name;
    is_directory  <= dir;
    header_sector <= sec;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic logic [NAME_W-1:0] random_text(input int unsigned len);
    logic [NAME_W-1:0] text;
    text = '0;
    for (int b = 0; b < len; b++) text[8*b +: 8] = 8'($urandom_range(255, 1));
    return text;
  endfunction

  // random bytes after the terminating zero, which must not matter
  function automatic logic [NAME_W-1:0] with_garbage(input logic [NAME_W-1:0] name);
    logic [NAME_W-1:0] noisy;
    int len;
    noisy = name;
    len = 0;
    while (len < NAME_BYTES && name[8*len +: 8] != 8'h00) len++;
    for (int b = len + 1; b < NAME_BYTES; b++) noisy[8*b +: 8] = 8'($urandom);
    return noisy;
  endfunction

  task automatic random_item(input bit filling);
    int unsigned roll;
    logic [NAME_W-1:0] name;
    logic [CMD_W-1:0] cmd;
    logic [SECTOR_W-1:0] sec;
    roll = $urandom_range(99);
    name = name_pool[$urandom_range(POOL - 1)];
    sec  = SECTOR_W'($urandom);
    if ($urandom_range(3) == 0) name = with_garbage(name);
    if (roll < 4) begin
      cmd  = CMD_UNUSED;
      name = {$urandom, $urandom};
    end else if (roll < 10) begin
      cmd  = (roll < 8) ? CMD_FIND : CMD_REMOVE;
      name = {$urandom, $urandom};
    end else if (filling) begin
      cmd = (roll < 60) ? CMD_ADD : (roll < 85) ? CMD_FIND : CMD_REMOVE;
    end else begin
      cmd = (roll < 25) ? CMD_ADD : (roll < 55) ? CMD_FIND : CMD_REMOVE;
    end
    send_item(cmd, name, 1'($urandom), sec);
  endtask

  initial begin
    for (int i = 0; i < POOL; i++) name_pool[i] = random_text($urandom_range(NAME_BYTES, 1));
    in_idle_pct = 19;
    out_idle_pct <= 45;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, unused command
    send_item(CMD_FIND, NAME_AB, FILE_KIND, 0);
    send_item(CMD_REMOVE, NAME_AB, FILE_KIND, 0);
    send_item(CMD_UNUSED, NAME_AB, FILE_KIND, 0);
    // duplicates, names equal after the terminator, same name of both kinds
    send_item(CMD_ADD, NAME_AB, FILE_KIND, TOP_SECTOR);
    send_item(CMD_ADD, NAME_AB, FILE_KIND, 7);
    send_item(CMD_ADD, NAME_AB_JUNK, FILE_KIND, 9);
    send_item(CMD_ADD, NAME_AB, DIR_KIND, 0);
    send_item(CMD_FIND, NAME_AB, FILE_KIND, 0);
    send_item(CMD_FIND, NAME_AB_JUNK, DIR_KIND, 0);
    // widest and empty names
    send_item(CMD_ADD, '1, DIR_KIND, TOP_SECTOR);
    send_item(CMD_ADD, '0, FILE_KIND, 341);
    send_item(CMD_ADD, NAME_EMPTY_JUNK, FILE_KIND, 682);
    send_item(CMD_FIND, NAME_EMPTY_JUNK, FILE_KIND, 0);
    send_item(CMD_FIND, '1, DIR_KIND, 0);
    send_item(CMD_FIND, '1, FILE_KIND, 0);
    // slot reuse with the other kind
    send_item(CMD_REMOVE, NAME_AB, FILE_KIND, 0);
    send_item(CMD_FIND, NAME_AB, FILE_KIND, 0);
    send_item(CMD_ADD, NAME_CD, DIR_KIND, 512);
    send_item(CMD_FIND, NAME_CD, FILE_KIND, 0);
    send_item(CMD_FIND, NAME_CD, DIR_KIND, 0);
    send_item(CMD_REMOVE, NAME_CD, DIR_KIND, 0);
    send_item(CMD_REMOVE, NAME_CD, DIR_KIND, 0);
    send_item(CMD_UNUSED, '1, DIR_KIND, TOP_SECTOR);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct = 19;
          out_idle_pct <= 45;
        end
        1: begin
          in_idle_pct = 45;
          out_idle_pct <= 19;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct <= 0;
        end
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 3; k++) random_item(((k / EPISODE) % 2) == 0);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 4) @(posedge clk);

    $display("tb: %0d items through the table: %0d ok, %0d not found, %0d duplicate, %0d full",
             sent, status_tally[ST_OK], status_tally[ST_NOT_FOUND],
             status_tally[ST_DUPLICATE], status_tally[ST_FULL]);
    $display("tb: fill and drain episodes under sender/receiver idling 19/45, 45/19 and none");
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
